>>> hw/rtl/sar_pkg.sv
// Shared constants, codes and types for the slot allocator.
`default_nettype none
package sar_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int COUNT_W = $clog2(SLOTS + 1);
  localparam int TIME_W  = 24;
  localparam int FUNC_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLAIM = 2'd0,
    FN_KEEP  = 2'd1,
    FN_TICK  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_POP_RD,
    ST_POP_WB,
    ST_KEEP_RD,
    ST_KEEP_WB,
    ST_TICK,
    ST_TICK_END,
    ST_CLEAR
  } state_t;

  // per-slot record held in memory
  typedef struct packed {
    logic              held_now;
    logic              held_before;
    logic              active;
    logic [TIME_W-1:0] timer;
    logic [TIME_W-1:0] hold;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic load;
    logic active;
  } drain_ctl_t;

  typedef struct packed {
    logic              active;
    logic              release_slot;
    logic [TIME_W-1:0] timer;
  } drain_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/sar_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/sar_drain.sv
// One drain-timer step for a single slot during a frame tick.
`default_nettype none
module sar_drain (
  input  wire  sar_pkg::drain_ctl_t          ctl,
  input  wire  logic [sar_pkg::TIME_W-1:0]   timer,
  input  wire  logic [sar_pkg::TIME_W-1:0]   hold,
  input  wire  logic [sar_pkg::TIME_W-1:0]   elapsed,
  output sar_pkg::drain_res_t                res
);
  import sar_pkg::*;

  logic [TIME_W-1:0] t;
  logic              act;

  assign t   = ctl.load ? hold : timer;
  assign act = ctl.active | ctl.load;

  always_comb begin
    res = '0;
    if (act) begin
      if (t <= elapsed) begin
        res.release_slot = 1'b1;
      end else begin
        res.active = 1'b1;
        res.timer  = t - elapsed;
      end
    end else begin
      res.timer = timer;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/slot_allocator_with_drain_release.sv
// Top level of the slot allocator with drained release.
//
// Command port: a beat is taken when start is high and busy is low; func
// selects claim, keep alive, frame tick or clear, with slot, drain_time and
// elapsed as operands. Each command gives one result beat: done is high for
// exactly one cycle with granted, granted_slot and free_count valid. The
// receiver cannot stall; free_count also follows the stack level at all
// times.
// busy stays high while a command runs and is low again in the cycle done is
// high, so a new command may be issued then. A claim that finds no free slot
// in its read state ends there, without a write-back.
// A tick walks the per-slot record memory (timers, drain times and hold
// flags) one slot a cycle: read, then update and write back in the next cycle;
// its single read port sets the tick length. Every write-back completes before
// the next beat is taken, so accesses to one record never overlap.
// Slots released by the tick are pushed onto the free stack unless it is full.
// Reset and the clear command zero the record memory in a pass over all
// SLOTS slots with busy high, and restore a full stack with slot 0 on top.
`default_nettype none
module slot_allocator_with_drain_release (
  input  wire  logic                         clk,
  input  wire  logic                         rst,
  input  wire  logic                         start,
  output logic                               busy,
  input  wire  logic [sar_pkg::FUNC_W-1:0]   func,
  input  wire  logic [sar_pkg::SLOT_W-1:0]   slot,
  input  wire  logic [sar_pkg::TIME_W-1:0]   drain_time,
  input  wire  logic [sar_pkg::TIME_W-1:0]   elapsed,
  output logic                               done,
  output logic                               granted,
  output logic [sar_pkg::SLOT_W-1:0]         granted_slot,
  output logic [sar_pkg::COUNT_W-1:0]        free_count
);
  import sar_pkg::*;

  state_t state, state_next;

  logic               accept;
  func_t              lat_func;
  logic [SLOT_W-1:0]  lat_slot;
  logic [TIME_W-1:0]  lat_dtime;
  logic [TIME_W-1:0]  lat_elapsed;

  logic [COUNT_W-1:0] free_top;
  logic [SLOTS-1:0]   stk_vld;

  logic [SLOT_W-1:0]  scan_idx;
  logic               p_vld;
  logic [SLOT_W-1:0]  p_idx;

  // stack memory
  logic               stk_we;
  logic [SLOT_W-1:0]  stk_waddr;
  logic [SLOT_W-1:0]  stk_raddr;
  logic [SLOT_W-1:0]  stk_rdata;
  logic [SLOT_W-1:0]  pop_slot;

  // record memory
  logic               rec_we;
  logic [SLOT_W-1:0]  rec_waddr;
  rec_t               rec_wdata;
  logic [SLOT_W-1:0]  rec_raddr;
  rec_t               rec_rdata;

  drain_ctl_t         dctl;
  drain_res_t         dres;

  logic               slot_ok;
  logic               stack_empty;
  logic               push;
  logic               pop_go;
  logic               done_next;
  logic               scan_last;
  logic               sweep;
  logic               scanning;

  assign busy        = (state != ST_IDLE);
  assign accept      = start & ~busy;
  assign slot_ok     = ({1'b0, lat_slot} < COUNT_W'(SLOTS));
  assign stack_empty = (free_top == '0);
  assign scan_last   = (scan_idx == SLOT_W'(SLOTS - 1));
  assign sweep       = (state == ST_CLEAR) | (state == ST_INIT);
  assign scanning    = (state == ST_TICK) | sweep;
  assign free_count  = free_top;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:     state_next = scan_last ? ST_IDLE : ST_INIT;
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(func))
            FN_CLAIM: state_next = ST_POP_RD;
            FN_KEEP:  state_next = ST_KEEP_RD;
            FN_TICK:  state_next = ST_TICK;
            FN_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_POP_RD:   state_next = stack_empty ? ST_IDLE : ST_POP_WB;
      ST_POP_WB:   state_next = ST_IDLE;
      ST_KEEP_RD:  state_next = ST_KEEP_WB;
      ST_KEEP_WB:  state_next = ST_IDLE;
      ST_TICK:     state_next = scan_last ? ST_TICK_END : ST_TICK;
      ST_TICK_END: state_next = ST_IDLE;
      ST_CLEAR:    state_next = scan_last ? ST_IDLE : ST_CLEAR;
      default:     state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    done_next = 1'b0;
    pop_go    = 1'b0;
    unique case (state)
      ST_POP_RD:   done_next = stack_empty;
      ST_POP_WB: begin
        done_next = 1'b1;
        pop_go    = 1'b1;
      end
      ST_KEEP_WB:  done_next = 1'b1;
      ST_TICK_END: done_next = 1'b1;
      ST_CLEAR:    done_next = scan_last;
      default:     done_next = 1'b0;
    endcase
  end

  // top of stack; free_top is unchanged between read and write-back
  assign stk_raddr = free_top[SLOT_W-1:0] - SLOT_W'(1);
  // entries never written since reset or clear still hold their reset order
  assign pop_slot  = stk_vld[stk_raddr] ? stk_rdata : SLOT_W'(SLOTS - 1) - stk_raddr;

  // tick pipeline: record read at scan_idx, update in the next cycle at p_idx
  assign dctl.load   = rec_rdata.held_before & ~rec_rdata.held_now;
  assign dctl.active = rec_rdata.active;

  sar_drain u_drain (
    .ctl     (dctl),
    .timer   (rec_rdata.timer),
    .hold    (rec_rdata.hold),
    .elapsed (lat_elapsed),
    .res     (dres)
  );

  assign push      = p_vld & dres.release_slot & (free_top < COUNT_W'(SLOTS));
  assign stk_we    = push;
  assign stk_waddr = free_top[SLOT_W-1:0];

  // the clearing pass writes a zero record per cycle
  assign rec_raddr = (state == ST_TICK) ? scan_idx : lat_slot;
  assign rec_we    = p_vld | ((state == ST_KEEP_WB) & slot_ok) | sweep;
  assign rec_waddr = p_vld ? p_idx : (sweep ? scan_idx : lat_slot);

  always_comb begin
    rec_wdata = '0;
    if (p_vld) begin
      // frame boundary: this frame's hold becomes last frame's
      rec_wdata.held_before = rec_rdata.held_now;
      rec_wdata.active      = dres.active;
      rec_wdata.timer       = dres.timer;
      rec_wdata.hold        = rec_rdata.hold;
    end else if (state == ST_KEEP_WB) begin
      rec_wdata          = rec_rdata;
      rec_wdata.held_now = 1'b1;
      rec_wdata.hold     = lat_dtime;
    end
  end

  sar_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (p_idx),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  sar_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      done     <= 1'b0;
      free_top <= COUNT_W'(SLOTS);
      stk_vld  <= '0;
      scan_idx <= '0;
      p_vld    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      p_vld <= (state == ST_TICK);

      if (scanning) begin
        scan_idx <= scan_idx + SLOT_W'(1);
      end

      if (pop_go) begin
        free_top <= free_top - COUNT_W'(1);
      end else if (push) begin
        free_top <= free_top + COUNT_W'(1);
      end

      if (push) begin
        stk_vld[free_top[SLOT_W-1:0]] <= 1'b1;
      end

      if (state == ST_CLEAR) begin
        free_top <= COUNT_W'(SLOTS);
        stk_vld  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lat_func    <= func_t'(func);
      lat_slot    <= slot;
      lat_dtime   <= drain_time;
      lat_elapsed <= elapsed;
    end
    p_idx <= scan_idx;
    if (done_next) begin
      granted      <= pop_go;
      granted_slot <= pop_go ? pop_slot : '0;
    end
  end

  // ---------------------------------------------------------------- checks
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    free_top <= COUNT_W'(SLOTS))
    else $error("free stack level beyond slot count");

  a_grant_level: assert property (@(posedge clk) disable iff (rst)
    done && granted |-> free_top < COUNT_W'(SLOTS))
    else $error("grant without a slot taken from the stack");

  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    free_top > $past(free_top) |->
      ($past(state) == ST_TICK || $past(state) == ST_TICK_END ||
       $past(state) == ST_CLEAR))
    else $error("free stack grew outside a tick or clear");

  a_keep_func: assert property (@(posedge clk) disable iff (rst)
    state == ST_KEEP_RD |-> lat_func == FN_KEEP)
    else $error("keep alive path entered for another command");

endmodule
`default_nettype wire

>>> tb/slot_allocator_with_drain_release_tb.sv
// Self-checking testbench for the slot allocator with drained release.
`timescale 1ns / 1ps
module slot_allocator_with_drain_release_tb;
  import sar_pkg::*;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  func;
  logic [SLOT_W-1:0]  slot;
  logic [TIME_W-1:0]  drain_time;
  logic [TIME_W-1:0]  elapsed;
  logic               done;
  logic               granted;
  logic [SLOT_W-1:0]  granted_slot;
  logic [COUNT_W-1:0] free_count;

  slot_allocator_with_drain_release DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .slot(slot), .drain_time(drain_time), .elapsed(elapsed),
    .done(done), .granted(granted), .granted_slot(granted_slot),
    .free_count(free_count)
  );

  typedef struct packed {
    logic               granted;
    logic [SLOT_W-1:0]  gslot;
    logic [COUNT_W-1:0] level;
  } alloc_result_t;

  // predictor state
  logic [SLOT_W-1:0]  free_list [SLOTS];
  logic [COUNT_W-1:0] free_level;
  logic [TIME_W-1:0]  drain_left [SLOTS];
  logic [TIME_W-1:0]  keep_time [SLOTS];
  logic               draining [SLOTS];
  logic               kept_this_frame [SLOTS];
  logic               kept_last_frame [SLOTS];

  alloc_result_t pending_results [$];

  int n_sent, n_mismatch;
  int n_granted, n_refused, n_keeps, n_ticks, n_clears, n_released, n_dropped;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("Timeout: %0d results still outstanding", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  function automatic void clear_model();
    for (int i = 0; i < SLOTS; i++) begin
      free_list[i]       = SLOT_W'(SLOTS - 1 - i);
      drain_left[i]      = '0;
      keep_time[i]       = '0;
      draining[i]        = 1'b0;
      kept_this_frame[i] = 1'b0;
      kept_last_frame[i] = 1'b0;
    end
    free_level = COUNT_W'(SLOTS);
  endfunction

  function automatic void push_free(int s);
    if (free_level < SLOTS) begin
      free_list[free_level] = SLOT_W'(s);
      free_level++;
      n_released++;
    end else begin
      n_dropped++;
    end
  endfunction

  function automatic void tick_model(logic [TIME_W-1:0] dt);
    for (int s = 0; s < SLOTS; s++) begin
      // released this frame: restart the drain from the recorded time
      if (kept_last_frame[s] && !kept_this_frame[s]) begin
        drain_left[s] = keep_time[s];
        draining[s]   = 1'b1;
      end
      if (draining[s]) begin
        if (drain_left[s] <= dt) begin
          drain_left[s] = '0;
          draining[s]   = 1'b0;
          push_free(s);
        end else begin
          drain_left[s] = drain_left[s] - dt;
        end
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      kept_last_frame[s] = kept_this_frame[s];
      kept_this_frame[s] = 1'b0;
    end
  endfunction

  function automatic alloc_result_t predict_alloc(func_t f, logic [SLOT_W-1:0] s,
                                                  logic [TIME_W-1:0] dt_keep,
                                                  logic [TIME_W-1:0] dt_tick);
    alloc_result_t r;
    r = '0;
    case (f)
      FN_CLAIM: begin
        if (free_level != 0) begin
          free_level--;
          r.gslot   = free_list[free_level];
          r.granted = 1'b1;
          n_granted++;
        end else begin
          n_refused++;
        end
      end
      FN_KEEP: begin
        kept_this_frame[s] = 1'b1;
        keep_time[s]       = dt_keep;
        n_keeps++;
      end
      FN_TICK: begin
        tick_model(dt_tick);
        n_ticks++;
      end
      FN_CLEAR: begin
        clear_model();
        n_clears++;
      end
      default: ;
    endcase
    r.level = free_level;
    return r;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    if (n_mismatch < 10)
      $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want, got);
    n_mismatch++;
  endfunction

  // result checking and prediction, both on the pre-edge values
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result beat, free_count", -1, free_count);
        end else begin
          want = pending_results.pop_front();
          if (granted !== want.granted) note_mismatch("granted", want.granted, granted);
          if (granted_slot !== want.gslot)
            note_mismatch("granted_slot", want.gslot, granted_slot);
          if (free_count !== want.level) note_mismatch("free_count", want.level, free_count);
        end
      end
      if (start && !busy)
        pending_results.insert(pending_results.size(),
                               predict_alloc(func_t'(func), slot, drain_time, elapsed));
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time(int small_max);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return TIME_W'($urandom);
    return TIME_W'($urandom_range(1, small_max));
  endfunction

  // one command beat; start stays high when the next beat follows at once
  task automatic send_cmd(func_t f, logic [SLOT_W-1:0] s,
                          logic [TIME_W-1:0] dt, logic [TIME_W-1:0] el);
    int gap;
    start      <= 1'b1;
    func       <= f;
    slot       <= s;
    drain_time <= dt;
    elapsed    <= el;
    do @(posedge clk); while (busy);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_claim();
    send_cmd(FN_CLAIM, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
  endtask

  task automatic send_keep(logic [SLOT_W-1:0] s, logic [TIME_W-1:0] dt);
    send_cmd(FN_KEEP, s, dt, TIME_W'($urandom));
  endtask

  task automatic send_tick(logic [TIME_W-1:0] el);
    send_cmd(FN_TICK, SLOT_W'($urandom), TIME_W'($urandom), el);
  endtask

  task automatic send_clear();
    send_cmd(FN_CLEAR, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
  endtask

  task automatic test_basic_ops();
    send_claim();
    send_claim();
    // zero drain, maximum drain and a slot that is already free
    send_keep(6'd0, '0);
    send_keep(6'd1, '1);
    send_keep(6'd63, 24'h000100);
    send_tick('0);
    // drains start; the third push lands on a full stack and is lost
    send_tick('1);
    send_keep(6'd5, 24'h000002);
    send_keep(6'd42, 24'hAAAAAA);
    send_keep(6'd21, 24'h555555);
    send_tick(24'h000000);
    send_tick(24'h000001);
    send_tick(24'h000000);
    send_tick(24'h000001);
    send_tick(24'h555555);
    send_tick(24'hAAAAAA);
    send_claim();
    send_claim();
    send_clear();
    send_claim();
    send_clear();
  endtask

  task automatic test_exhaust_and_refill();
    repeat (SLOTS + 2) send_claim();
    send_keep(6'd3, 24'h000010);
    send_keep(6'd60, 24'h000000);
    send_keep(6'd17, 24'h000020);
    send_tick(24'h000008);
    send_tick(24'h000008);
    send_tick(24'h000010);
    repeat (4) send_claim();
    send_clear();
  endtask

  task automatic test_frame_traffic(int target);
    int frame;
    frame = 0;
    while (n_sent < target) begin
      if (frame % 25 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 2) send_clear();
      if ($urandom_range(0, 29) == 0) repeat ($urandom_range(20, 70)) send_claim();
      repeat ($urandom_range(0, 4)) send_claim();
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 9) < 8) send_keep(SLOT_W'($urandom_range(0, 15)), pick_time(768));
        else send_keep(SLOT_W'($urandom), pick_time(768));
      end
      send_tick(pick_time(512));
      frame++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_noise(int count);
    repeat (count)
      send_cmd(func_t'($urandom_range(0, 3)), SLOT_W'($urandom), TIME_W'($urandom),
               TIME_W'($urandom));
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    func       = '0;
    slot       = '0;
    drain_time = '0;
    elapsed    = '0;
    no_idle    = 1'b0;
    clear_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_exhaust_and_refill();
    test_frame_traffic(1380);
    test_noise(150);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);

    $display("Covered %0d commands: %0d claims granted, %0d refused, %0d keep-alives,",
             n_sent, n_granted, n_refused, n_keeps);
    $display("%0d frame ticks, %0d clears, %0d slots returned, %0d pushes lost on a full stack",
             n_ticks, n_clears, n_released, n_dropped);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
